// ===== design/latency_spike_jitter_detector_defines.svh =====
// Assertion macros shared by the latency spike and jitter detector RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef LATENCY_SPIKE_JITTER_DETECTOR_DEFINES_SVH
`define LATENCY_SPIKE_JITTER_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSJD_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lsjd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LSJD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lsjd: next-cycle check failed");

// Condition that must hold at every edge out of reset.
`define LSJD_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lsjd: invariant check failed");

`endif

// ===== design/lsjd_pkg.sv =====
// Package for the latency spike and jitter detector: payload types, register
// indices, reset values and arithmetic constants. No dependencies.
package lsjd_pkg;

    localparam int PING_BITS_DEF = 16;
    localparam int IN_BITS       = 16;
    localparam int OUT_BITS      = 16;
    localparam int MS_BITS       = 10;
    localparam int PCT_BITS      = 10;
    localparam int CNT_BITS      = 6;
    localparam int EV_BITS       = 5;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [MS_BITS-1:0]  SPIKE_MS_RST      = 10'd50;
    localparam logic [PCT_BITS-1:0] SPIKE_PERCENT_RST = 10'd50;
    localparam logic [MS_BITS-1:0]  JITTER_MS_RST     = 10'd20;
    localparam logic                ADAPTIVE_RST      = 1'b1;

    localparam logic [MS_BITS-1:0]  MAX_MS       = 10'd999;
    localparam logic [PCT_BITS-1:0] MAX_PCT      = 10'd1000;
    localparam logic [MS_BITS-1:0]  SPIKE_MIN_MS = 10'd20;
    localparam logic [MS_BITS-1:0]  JIT_FLOOR    = 10'd10;
    localparam logic [CNT_BITS-1:0] WARMUP       = 6'd32;
    localparam longint PCT_SCALE = 100;

    // Bit positions within event_flags.
    localparam int EV_SPIKE  = 0;
    localparam int EV_JITTER = 1;
    localparam int EV_LOSS   = 2;
    localparam int EV_CHOKE  = 3;
    localparam int EV_CDROP  = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SPIKE_MS      = 4'd0,
        CFG_SPIKE_PERCENT = 4'd1,
        CFG_JITTER_MS     = 4'd2,
        CFG_ADAPTIVE_MODE = 4'd3
    } cfg_idx_e;

    typedef struct packed {
        logic [IN_BITS-1:0] ping_ms;
        logic               server_drop;
        logic               client_drop;
        logic               suppressed;
    } sample_t;

    typedef struct packed {
        logic [EV_BITS-1:0]  event_flags;
        logic [OUT_BITS-1:0] average_ping;
        logic [OUT_BITS-1:0] shown_ping;
        logic [OUT_BITS-1:0] jitter_level;
    } result_t;

endpackage

// ===== design/lsjd_interfaces.sv =====
// Valid/ready channel interfaces for samples, results and register writes.
// Depends on lsjd_pkg for the payload types and field widths.
interface lsjd_sample_if;
    import lsjd_pkg::*;
    logic    valid;
    logic    ready;
    sample_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lsjd_result_if;
    import lsjd_pkg::*;
    logic    valid;
    logic    ready;
    result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lsjd_cfg_if;
    import lsjd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/lsjd_detect.sv =====
// Threshold derivation and spike/jitter tests for one sample.
// Depends on lsjd_pkg; the average-times-percent product arrives registered.
module lsjd_detect #(
    parameter int PING_BITS = lsjd_pkg::PING_BITS_DEF
) (
    input  logic [PING_BITS+lsjd_pkg::PCT_BITS-1:0] prod,
    input  logic [PING_BITS-1:0]                    avg,
    input  logic [PING_BITS-1:0]                    baseline,
    input  logic [PING_BITS-1:0]                    jit_est,
    input  logic [PING_BITS-1:0]                    ping,
    input  logic [lsjd_pkg::MS_BITS-1:0]            s_ms,
    input  logic [lsjd_pkg::MS_BITS-1:0]            j_ms,
    input  logic                                    adaptive,
    input  logic                                    warm,
    output logic                                    spike_hit,
    output logic                                    jitter_hit
);
    import lsjd_pkg::*;

    localparam int PROD_W  = PING_BITS + PCT_BITS;
    localparam int SHIFT   = PROD_W + 7;
    localparam int RECIP_W = SHIFT - 5;
    localparam int MUL_W   = PROD_W + RECIP_W;
    localparam int THR_W   = PING_BITS + 4;
    // Rounded-up reciprocal of the percent scale; exact floor for every product.
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + PCT_SCALE - 1) / PCT_SCALE);

    logic [MUL_W-1:0]   scaled;
    logic [THR_W-1:0]   pct_term;
    logic [MS_BITS-1:0] s_floor;
    logic [MS_BITS-1:0] j_floor;
    logic [THR_W-1:0]   jit_sum;
    logic [THR_W-1:0]   spike_thr;
    logic [THR_W-1:0]   jit_thr;
    logic [THR_W:0]     spike_lim;

    always_comb
    begin
        scaled   = MUL_W'(prod) * MUL_W'(RECIP);
        pct_term = scaled[SHIFT +: THR_W];
        s_floor  = (s_ms > SPIKE_MIN_MS) ? s_ms : SPIKE_MIN_MS;
        j_floor  = (j_ms > JIT_FLOOR) ? j_ms : JIT_FLOOR;

        if (adaptive)
        begin
            spike_thr = (THR_W'(s_floor) > pct_term) ? THR_W'(s_floor) : pct_term;
            jit_sum   = THR_W'(baseline) + (spike_thr >> 2);
            jit_thr   = (THR_W'(j_floor) > jit_sum) ? THR_W'(j_floor) : jit_sum;
        end
        else
        begin
            spike_thr = THR_W'(s_ms);
            jit_sum   = THR_W'(baseline);
            jit_thr   = THR_W'(j_ms);
        end

        spike_lim  = (THR_W+1)'(avg) + (THR_W+1)'(spike_thr);
        spike_hit  = warm && (spike_thr != '0) && ((THR_W+1)'(ping) > spike_lim);
        jitter_hit = warm && (jit_thr != '0) && (THR_W'(jit_est) >= jit_thr);
    end

endmodule

// ===== design/latency_spike_jitter_detector.sv =====
// A sample accepted into the input register moves to the result register when that
// register is empty or its result is taken. Throughput: one sample per cycle while
// results are taken; the input register refills while a result waits.
// The average-times-percent product is kept registered beside the average state.
// Reset (asynchronous, active low) clears all statistics and the warm-up count and
// loads the register defaults: spike 50 ms, 50 percent, jitter 20 ms, adaptive on.
`include "latency_spike_jitter_detector_defines.svh"

module latency_spike_jitter_detector #(
    parameter int PING_BITS = lsjd_pkg::PING_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lsjd_sample_if.sink   samples,
    lsjd_result_if.source results,
    lsjd_cfg_if.sink      cfg
);
    import lsjd_pkg::*;

    localparam int PROD_W = PING_BITS + PCT_BITS;
    localparam int SUM3_W = PING_BITS + 3;
    localparam int SUM4_W = PING_BITS + 4;

    logic [MS_BITS-1:0]  spike_ms_reg;
    logic [PCT_BITS-1:0] spike_percent_reg;
    logic [MS_BITS-1:0]  jitter_ms_reg;
    logic                adaptive_reg;

    logic    s1_valid_reg;
    sample_t s1_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic [PING_BITS-1:0] avg_latency_reg, avg_latency_next;
    logic [PING_BITS-1:0] display_latency_reg, display_latency_next;
    logic [PING_BITS-1:0] previous_latency_reg, previous_latency_next;
    logic [PING_BITS-1:0] jitter_estimate_reg, jitter_estimate_next;
    logic [PING_BITS-1:0] jitter_baseline_reg, jitter_baseline_next;
    logic [CNT_BITS-1:0]  accepted_count_reg, accepted_count_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;

    logic                 advance;
    logic                 counted;
    logic                 warm;
    logic [PING_BITS-1:0] ping;
    logic [MS_BITS-1:0]   s_ms;
    logic [PCT_BITS-1:0]  s_pct;
    logic [MS_BITS-1:0]   j_ms;
    logic [SUM3_W-1:0]    disp_sum;
    logic [SUM3_W-1:0]    avg_sum;
    logic [SUM3_W-1:0]    jit_sum;
    logic [SUM4_W-1:0]    base_sum;
    logic [PING_BITS-1:0] delta;
    logic                 spike_hit;
    logic                 jitter_hit;
    logic [EV_BITS-1:0]   events;

    assign advance       = s1_valid_reg && (!out_valid_reg || results.ready);
    assign samples.ready = !s1_valid_reg || advance;
    assign cfg.ready     = 1'b1;
    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

    assign ping    = PING_BITS'(s1_reg.ping_ms);
    assign counted = !s1_reg.server_drop && !s1_reg.client_drop;
    assign warm    = accepted_count_reg >= WARMUP;
    assign s_ms    = (spike_ms_reg > MAX_MS) ? MAX_MS : spike_ms_reg;
    assign s_pct   = (spike_percent_reg > MAX_PCT) ? MAX_PCT : spike_percent_reg;
    assign j_ms    = (jitter_ms_reg > MAX_MS) ? MAX_MS : jitter_ms_reg;

    lsjd_detect #(
        .PING_BITS (PING_BITS)
    ) u_detect (
        .prod       (prod_reg),
        .avg        (avg_latency_reg),
        .baseline   (jitter_baseline_reg),
        .jit_est    (jitter_estimate_reg),
        .ping       (ping),
        .s_ms       (s_ms),
        .j_ms       (j_ms),
        .adaptive   (adaptive_reg),
        .warm       (warm),
        .spike_hit  (spike_hit),
        .jitter_hit (jitter_hit)
    );

    always_comb
    begin
        disp_sum = SUM3_W'({display_latency_reg, 1'b0}) + SUM3_W'(display_latency_reg)
                 + SUM3_W'(ping) + SUM3_W'(2);
        avg_sum  = SUM3_W'({avg_latency_reg, 3'b000}) - SUM3_W'(avg_latency_reg)
                 + SUM3_W'(ping);
        delta    = (ping >= previous_latency_reg) ? ping - previous_latency_reg
                                                  : previous_latency_reg - ping;
        jit_sum  = SUM3_W'({jitter_estimate_reg, 3'b000}) - SUM3_W'(jitter_estimate_reg)
                 + SUM3_W'(delta);

        display_latency_next  = display_latency_reg;
        avg_latency_next      = avg_latency_reg;
        previous_latency_next = previous_latency_reg;
        jitter_estimate_next  = jitter_estimate_reg;
        jitter_baseline_next  = jitter_baseline_reg;
        accepted_count_next   = accepted_count_reg;

        if (advance)
        begin
            display_latency_next = (accepted_count_reg == '0) ? ping
                                                              : disp_sum[2 +: PING_BITS];
            if (counted)
            begin
                avg_latency_next = (accepted_count_reg == '0) ? ping
                                                              : avg_sum[3 +: PING_BITS];
                if (accepted_count_reg != '0)
                begin
                    jitter_estimate_next = jit_sum[3 +: PING_BITS];
                end
                previous_latency_next = ping;
                if (accepted_count_reg < WARMUP)
                begin
                    accepted_count_next = accepted_count_reg + CNT_BITS'(1);
                end
            end
        end

        base_sum = SUM4_W'({jitter_baseline_reg, 4'b0000}) - SUM4_W'(jitter_baseline_reg)
                 + SUM4_W'(jitter_estimate_next);
        if (advance && counted && (accepted_count_reg != '0))
        begin
            if (accepted_count_reg == CNT_BITS'(1))
            begin
                jitter_baseline_next = jitter_estimate_next;
            end
            else if ((PING_BITS+1)'(jitter_estimate_next)
                     < (PING_BITS+1)'(jitter_baseline_reg) + (PING_BITS+1)'(2))
            begin
                jitter_baseline_next = base_sum[4 +: PING_BITS];
            end
        end

        // The product follows the average every cycle, so it is fresh for the next sample.
        prod_next = PROD_W'(avg_latency_next) * PROD_W'(s_pct);

        events            = '0;
        events[EV_SPIKE]  = counted && spike_hit;
        events[EV_JITTER] = counted && jitter_hit;
        events[EV_LOSS]   = s1_reg.server_drop;
        events[EV_CHOKE]  = s1_reg.suppressed;
        events[EV_CDROP]  = s1_reg.client_drop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spike_ms_reg      <= SPIKE_MS_RST;
            spike_percent_reg <= SPIKE_PERCENT_RST;
            jitter_ms_reg     <= JITTER_MS_RST;
            adaptive_reg      <= ADAPTIVE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_SPIKE_MS:      spike_ms_reg      <= MS_BITS'(cfg.data);
                CFG_SPIKE_PERCENT: spike_percent_reg <= PCT_BITS'(cfg.data);
                CFG_JITTER_MS:     jitter_ms_reg     <= MS_BITS'(cfg.data);
                CFG_ADAPTIVE_MODE: adaptive_reg      <= cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_latency_reg      <= '0;
            display_latency_reg  <= '0;
            previous_latency_reg <= '0;
            jitter_estimate_reg  <= '0;
            jitter_baseline_reg  <= '0;
            accepted_count_reg   <= '0;
            prod_reg             <= '0;
        end
        else
        begin
            avg_latency_reg      <= avg_latency_next;
            display_latency_reg  <= display_latency_next;
            previous_latency_reg <= previous_latency_next;
            jitter_estimate_reg  <= jitter_estimate_next;
            jitter_baseline_reg  <= jitter_baseline_next;
            accepted_count_reg   <= accepted_count_next;
            prod_reg             <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (samples.valid && samples.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            s1_reg <= samples.payload;
        end
        if (advance)
        begin
            out_reg.event_flags  <= events;
            out_reg.average_ping <= OUT_BITS'(avg_latency_next);
            out_reg.shown_ping   <= OUT_BITS'(display_latency_next);
            out_reg.jitter_level <= OUT_BITS'(jitter_estimate_next);
        end
    end

    // A dropped sample must leave the average untouched.
    `LSJD_ASSERT_NEXT(a_drop_keeps_avg, clk, rst_n, advance && !counted, $stable(avg_latency_reg))
    // The first counted sample loads average and display with the same value.
    `LSJD_ASSERT_NEXT(a_first_load, clk, rst_n,
        advance && counted && (accepted_count_reg == '0),
        avg_latency_reg == display_latency_reg)
    // The warm-up count steps by one per counted sample until it saturates.
    `LSJD_ASSERT_NEXT(a_count_step, clk, rst_n,
        advance && counted && (accepted_count_reg < WARMUP),
        accepted_count_reg == $past(accepted_count_reg) + CNT_BITS'(1))
    `LSJD_ASSERT_ALWAYS(a_count_sat, clk, rst_n, accepted_count_reg <= WARMUP)

endmodule
